// File: sv/cnv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 reflect-padded convolution block.
// No dependencies; cnv_seq, cnv_mac and the top level import this package.
package cnv_pkg;

  // Fixed field widths of the command and result beats
  localparam int CH_W    = 3;
  localparam int POS_W   = 6;
  localparam int TAP_W   = 2;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int FRAC_W  = 12;

  // Configuration register file
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int CNT_W     = 4;
  localparam int DIM_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IN_CH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd3;

  localparam logic [CNT_W-1:0] RST_IN_CH  = 4'd4;
  localparam logic [CNT_W-1:0] RST_OUT_CH = 4'd4;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd8;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd8;

  // Smallest plane edge that reflect padding works with
  localparam logic [DIM_W-1:0] MIN_DIM = 7'd2;

  // Kernel taps run 0..2
  localparam logic [TAP_W-1:0] TAP_LAST = 2'd2;
  localparam int               TAP_NUM  = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_PIXEL  = 2'd0,
    CMD_LOAD_WEIGHT = 2'd1,
    CMD_LOAD_BIAS   = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic [CH_W-1:0]          dst_chan;
    logic [CH_W-1:0]          src_chan;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic [TAP_W-1:0]         tap_row;
    logic [TAP_W-1:0]         tap_col;
    logic signed [VAL_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]          result_channel;
    logic [POS_W-1:0]         result_row;
    logic [POS_W-1:0]         result_col;
    logic signed [ACC_W-1:0]  result_value;
  } out_beat_t;

  // Per-step control that travels alongside the memory reads
  typedef struct packed {
    logic vld;   // a product belongs to this step
    logic last;  // final step of the pixel
  } cnv_ctl_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

endpackage

// File: sv/cnv_ram.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; used for the image and weight stores.
module cnv_ram #(
  parameter int DW = 16,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cnv_seq.sv
`timescale 1ns / 1ps
// Tap sequencer: walks input channels and the 3x3 kernel, mirrors neighbor
// coordinates at the plane edges and issues image and weight read addresses.
// Depends on cnv_pkg.
module cnv_seq #(
  parameter int CH_AW = 3,
  parameter int RAW   = 6,
  parameter int CAW   = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [cnv_pkg::CNT_W-1:0]         nin,
  input  logic [cnv_pkg::DIM_W-1:0]         h_eff,
  input  logic [cnv_pkg::DIM_W-1:0]         w_eff,
  input  logic [cnv_pkg::CH_W-1:0]          oc,
  input  logic [cnv_pkg::POS_W-1:0]         row,
  input  logic [cnv_pkg::POS_W-1:0]         col,
  output logic [CH_AW+RAW+CAW-1:0]          img_addr,
  output logic [2*CH_AW+2*cnv_pkg::TAP_W-1:0] wgt_addr,
  output cnv_pkg::cnv_ctl_t                 ctl
);
  import cnv_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] ch_r, ch_nxt;
  logic [TAP_W-1:0] ky_r, ky_nxt;
  logic [TAP_W-1:0] kx_r, kx_nxt;
  logic             last_step;
  logic [DIM_W-1:0] sy, sx;

  // Mirror pos+tap-1 into [0, size); t carries the +1 offset so it stays unsigned
  function automatic logic [DIM_W-1:0] reflect(input logic [POS_W-1:0] pos,
                                               input logic [TAP_W-1:0] tap,
                                               input logic [DIM_W-1:0] size);
    logic [DIM_W:0] t;
    logic [DIM_W:0] size_p1;
    logic [DIM_W:0] mirrored;
    t        = (DIM_W+1)'(pos) + (DIM_W+1)'(tap);
    size_p1  = (DIM_W+1)'(size) + 1'b1;
    mirrored = (DIM_W+1)'(size) - (DIM_W+1)'(MIN_DIM);
    if (t == '0) begin
      reflect = DIM_W'(1);
    end else if (t == size_p1) begin
      reflect = mirrored[DIM_W-1:0];
    end else begin
      reflect = DIM_W'(t - 1'b1);
    end
  endfunction

  assign last_step = (ky_r == TAP_LAST) && (kx_r == TAP_LAST) &&
                     (CNT_W'(ch_r + 1'b1) == nin);

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    ky_nxt    = ky_r;
    kx_nxt    = kx_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (go) begin
          state_nxt = SEQ_RUN;
          ch_nxt    = '0;
          ky_nxt    = '0;
          kx_nxt    = '0;
        end
      end
      SEQ_RUN: begin
        if (nin == '0 || last_step) begin
          state_nxt = SEQ_IDLE;
        end else if (kx_r != TAP_LAST) begin
          kx_nxt = kx_r + 1'b1;
        end else if (ky_r != TAP_LAST) begin
          kx_nxt = '0;
          ky_nxt = ky_r + 1'b1;
        end else begin
          kx_nxt = '0;
          ky_nxt = '0;
          ch_nxt = ch_r + 1'b1;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      ch_r    <= '0;
      ky_r    <= '0;
      kx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      ky_r    <= ky_nxt;
      kx_r    <= kx_nxt;
    end
  end

  assign sy = reflect(row, ky_r, h_eff);
  assign sx = reflect(col, kx_r, w_eff);

  assign img_addr = {CH_AW'(ch_r), RAW'(sy), CAW'(sx)};
  assign wgt_addr = {CH_AW'(oc), CH_AW'(ch_r), ky_r, kx_r};

  assign ctl.vld  = (state_r == SEQ_RUN) && (nin != '0);
  assign ctl.last = (state_r == SEQ_RUN) && ((nin == '0) || last_step);

endmodule

// File: sv/cnv_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate datapath: registered product, then a 40-bit accumulator
// seeded with the bias. Depends on cnv_pkg.
module cnv_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                init,
  input  logic signed [cnv_pkg::VAL_W-1:0]    bias,
  input  cnv_pkg::cnv_ctl_t                   ctl,
  input  logic signed [cnv_pkg::VAL_W-1:0]    px,
  input  logic signed [cnv_pkg::VAL_W-1:0]    wt,
  output logic                                done,
  output logic signed [cnv_pkg::ACC_W-1:0]    acc
);
  import cnv_pkg::*;

  cnv_ctl_t                  ctl1_r, ctl2_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      done_r;

  assign prod_nxt = px * wt;

  always_comb begin
    acc_nxt = acc_r;
    if (init) begin
      acc_nxt = {{(ACC_W-VAL_W-FRAC_W){bias[VAL_W-1]}}, bias, {FRAC_W{1'b0}}};
    end else if (ctl2_r.vld) begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // Align control with read data (stage 1) and with the product (stage 2)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// File: sv/conv2d_3x3_reflect_pad.sv
`timescale 1ns / 1ps
// Top level of the multi-channel 3x3 convolution with reflect padding.
// Depends on cnv_pkg, cnv_ram, cnv_seq and cnv_mac.
//
//   Channel  Ports                                Handshake
//   -------  -----------------------------------  ----------------------------------
//   input    start, busy, in_data (in_beat_t)     beat taken when start && !busy
//   result   out_valid, out_data (out_beat_t)     one-cycle strobe, cannot be held
//   config   cfg_we, cfg_index, cfg_wdata         write when cfg_we, no wait
//
// Load commands (pixel, weight, bias) never raise busy; the store is written at the
// accepting edge. An in-bounds compute beat raises busy and walks the input channel
// count x 9 taps, one image/weight read pair per cycle from the two single-read
// RAMs (a zero channel count gives the bias alone); the result strobes once the
// last tap has passed the read, product and done registers, and busy drops in that
// same cycle, so the next beat can be accepted there. Reset (synchronous, rst_n low)
// restores the register defaults and clears the bias store through per-entry
// valid bits; image and weight stores are not cleared. There is no output stall.
module conv2d_3x3_reflect_pad #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  cnv_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  output cnv_pkg::out_beat_t                 out_data,
  input  logic                               cfg_we,
  input  logic [cnv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cnv_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import cnv_pkg::*;

  // Stores use sparse {channel, row, col} and {out, in, tap_row, tap_col} addressing
  localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RAW    = $clog2(MAX_HEIGHT);
  localparam int CAW    = $clog2(MAX_WIDTH);
  localparam int IMG_AW = CH_AW + RAW + CAW;
  localparam int WGT_AW = 2 * CH_AW + 2 * TAP_W;

  // Configuration registers
  logic [CNT_W-1:0] cfg_nin_r, cfg_nout_r;
  logic [DIM_W-1:0] cfg_h_r, cfg_w_r;

  // Effective (saturated) configuration
  logic [CNT_W-1:0] nin, nout;
  logic [DIM_W-1:0] h_eff, w_eff;

  // Command handling
  logic            accept;
  logic            busy_r, busy_nxt;
  logic            go, go_d_r;
  logic            pix_ok, wgt_ok, bias_ok, comp_ok;
  logic            img_we, wgt_we, bias_we;
  logic [CH_W-1:0] oc_r;
  logic [POS_W-1:0] row_r, col_r;

  // Bias store: flops-free memory plus per-entry valid bits that reset clears
  logic signed [VAL_W-1:0] bias_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] bias_vld_r;
  logic signed [VAL_W-1:0] bias_rd_r;
  logic                    bias_hit_r;
  logic signed [VAL_W-1:0] bias_val;

  // Datapath
  logic [IMG_AW-1:0]       img_raddr;
  logic [WGT_AW-1:0]       wgt_raddr;
  logic [VAL_W-1:0]        img_rdata, wgt_rdata;
  cnv_ctl_t                seq_ctl;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_acc;

  // Write the register file; no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nin_r  <= RST_IN_CH;
      cfg_nout_r <= RST_OUT_CH;
      cfg_h_r    <= RST_HEIGHT;
      cfg_w_r    <= RST_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_CH:  cfg_nin_r  <= cfg_wdata[CNT_W-1:0];
        REG_OUT_CH: cfg_nout_r <= cfg_wdata[CNT_W-1:0];
        REG_HEIGHT: cfg_h_r    <= cfg_wdata;
        REG_WIDTH:  cfg_w_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate counts to the store size, plane edges into [2, MAX]
  assign nin  = (32'(cfg_nin_r) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : cfg_nin_r;
  assign nout = (32'(cfg_nout_r) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : cfg_nout_r;

  always_comb begin
    priority if (cfg_h_r < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_r;
    end
    priority if (cfg_w_r < MIN_DIM) begin
      w_eff = MIN_DIM;
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_w_r;
    end
  end

  // Bounds checks: loads against the store sizes, compute against the output channel count and configured plane
  assign pix_ok  = (32'(in_data.src_chan) < MAX_CHANNELS) &&
                   (32'(in_data.row) < MAX_HEIGHT) && (32'(in_data.col) < MAX_WIDTH);
  assign wgt_ok  = (32'(in_data.dst_chan) < MAX_CHANNELS) &&
                   (32'(in_data.src_chan) < MAX_CHANNELS) &&
                   (in_data.tap_row <= TAP_LAST) && (in_data.tap_col <= TAP_LAST);
  assign bias_ok = (32'(in_data.dst_chan) < MAX_CHANNELS);
  assign comp_ok = (CNT_W'(in_data.dst_chan) < nout) &&
                   (DIM_W'(in_data.row) < h_eff) && (DIM_W'(in_data.col) < w_eff);

  assign accept = start && !busy;

  always_comb begin
    img_we  = 1'b0;
    wgt_we  = 1'b0;
    bias_we = 1'b0;
    go      = 1'b0;
    if (accept) begin
      unique case (in_data.command)
        CMD_LOAD_PIXEL:  img_we  = pix_ok;
        CMD_LOAD_WEIGHT: wgt_we  = wgt_ok;
        CMD_LOAD_BIAS:   bias_we = bias_ok;
        CMD_COMPUTE:     go      = comp_ok;
        default: ;
      endcase
    end
  end

  // Hold busy from compute accept until the result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (mac_done) begin
      busy_nxt = 1'b0;
    end
    if (go) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      go_d_r     <= 1'b0;
      bias_vld_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      go_d_r <= go;
      if (bias_we) begin
        bias_vld_r[CH_AW'(in_data.dst_chan)] <= 1'b1;
      end
    end
  end

  assign busy = busy_r && !mac_done;

  // Latch the pixel being computed; it also labels the result
  always_ff @(posedge clk) begin
    if (go) begin
      oc_r  <= in_data.dst_chan;
      row_r <= in_data.row;
      col_r <= in_data.col;
    end
  end

  // Bias memory: write on load, read at compute accept
  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[CH_AW'(in_data.dst_chan)] <= in_data.value;
    end
    bias_rd_r  <= bias_mem[CH_AW'(in_data.dst_chan)];
    bias_hit_r <= bias_vld_r[CH_AW'(in_data.dst_chan)];
  end

  // Never-written bias entries read as zero
  assign bias_val = bias_hit_r ? bias_rd_r : '0;

  cnv_ram #(
    .DW (VAL_W),
    .AW (IMG_AW)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr ({CH_AW'(in_data.src_chan), RAW'(in_data.row), CAW'(in_data.col)}),
    .wdata (in_data.value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  cnv_ram #(
    .DW (VAL_W),
    .AW (WGT_AW)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr ({CH_AW'(in_data.dst_chan), CH_AW'(in_data.src_chan),
             in_data.tap_row, in_data.tap_col}),
    .wdata (in_data.value),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  cnv_seq #(
    .CH_AW (CH_AW),
    .RAW   (RAW),
    .CAW   (CAW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .nin      (nin),
    .h_eff    (h_eff),
    .w_eff    (w_eff),
    .oc       (oc_r),
    .row      (row_r),
    .col      (col_r),
    .img_addr (img_raddr),
    .wgt_addr (wgt_raddr),
    .ctl      (seq_ctl)
  );

  // Seed the accumulator with the bias in the first sequencer cycle
  cnv_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (go_d_r),
    .bias  (bias_val),
    .ctl   (seq_ctl),
    .px    ($signed(img_rdata)),
    .wt    ($signed(wgt_rdata)),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  // Result beat: accumulator and latched coordinates stay put during the strobe
  assign out_valid               = mac_done;
  assign out_data.result_channel = oc_r;
  assign out_data.result_row     = row_r;
  assign out_data.result_col     = col_r;
  assign out_data.result_value   = mac_acc;

endmodule
